/* rtl/core/psb_pkg.sv */
// ----------------------------------------------------------------------------
// psb_pkg: shared definitions for the power sequencer
// Supply state codes, request codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package psb_pkg;

  localparam int STATE_W = 4;
  localparam int TIME_W  = 16;
  localparam int REQ_W   = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Supply state encoding, shared by the sensed, current and desired states.
  localparam logic [STATE_W-1:0] ST_INIT      = 4'd0;
  localparam logic [STATE_W-1:0] ST_PWR_ON    = 4'd1;
  localparam logic [STATE_W-1:0] ST_PWR_OFF   = 4'd2;
  localparam logic [STATE_W-1:0] ST_CYCLE     = 4'd3;
  localparam logic [STATE_W-1:0] ST_ON        = 4'd4;
  localparam logic [STATE_W-1:0] ST_OFF       = 4'd5;
  localparam logic [STATE_W-1:0] ST_FAULT     = 4'd6;
  localparam logic [STATE_W-1:0] ST_FAULT_ON  = 4'd7;
  localparam logic [STATE_W-1:0] ST_FAULT_OFF = 4'd8;

  // Request types.
  localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SET     = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STARTUP = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_OFF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_TIMEOUT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_TIMEOUT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_ON     = 3'd5;

  // Register reset values.
  localparam logic [TIME_W-1:0] DEBOUNCE_RST    = 16'd100;
  localparam logic [TIME_W-1:0] LONG_PRESS_RST  = 16'd500;
  localparam logic [TIME_W-1:0] CYCLE_OFF_RST   = 16'd1000;
  localparam logic [TIME_W-1:0] ON_TIMEOUT_RST  = 16'd2000;
  localparam logic [TIME_W-1:0] OFF_TIMEOUT_RST = 16'd2000;

  localparam logic [TIME_W-1:0] HELD_MAX = {TIME_W{1'b1}};

  // What the button handler hands to the sequencer for one tick.
  typedef struct packed {
    logic [STATE_W-1:0] want;
    logic               press;
  } psb_btn_t;

endpackage

/* rtl/core/psb_if.sv */
// ----------------------------------------------------------------------------
// psb_in_if / psb_out_if: request and status channels
// Valid/ready channels carrying one request item or one status item.
// ----------------------------------------------------------------------------
interface psb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic       button_raw;
  logic [3:0] sensed_state;
  logic [3:0] requested_state;
  logic       cold_start;

  modport source (output valid, req_type, button_raw, sensed_state, requested_state,
                  cold_start, input ready);
  modport sink (input valid, req_type, button_raw, sensed_state, requested_state,
                cold_start, output ready);
endinterface

interface psb_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] supply_state;
  logic [3:0] target_state;
  logic       supply_off_drive;
  logic       press_seen;

  modport source (output valid, supply_state, target_state, supply_off_drive, press_seen,
                  input ready);
  modport sink (input valid, supply_state, target_state, supply_off_drive, press_seen,
                output ready);
endinterface

/* rtl/core/psb_button.sv */
// ----------------------------------------------------------------------------
// psb_button: power button debounce and press handling
// Debounces the button once per tick and updates the desired supply state.
// ----------------------------------------------------------------------------
module psb_button
  import psb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               tick,
  input  logic               level,
  input  logic [TIME_W-1:0]  debounce_ms,
  input  logic [TIME_W-1:0]  long_press_ms,
  input  logic [STATE_W-1:0] cur_state,
  input  logic [STATE_W-1:0] want_state,
  output psb_btn_t           btn
);

  logic              last_level, last_level_next;
  logic              debouncing, debouncing_next;
  logic [TIME_W-1:0] debounce_timer, debounce_timer_next;
  logic              armed, armed_next;
  logic [TIME_W-1:0] held_ticks, held_ticks_next;

  always_comb begin
    logic              act;
    logic [TIME_W-1:0] dt_dec;
    last_level_next     = last_level;
    debouncing_next     = debouncing;
    debounce_timer_next = debounce_timer;
    armed_next          = armed;
    held_ticks_next     = held_ticks;
    btn.want            = want_state;
    btn.press           = 1'b0;
    act                 = 1'b0;
    dt_dec              = (debounce_timer != '0) ? debounce_timer - 1'b1 : '0;

    if (level != last_level) begin
      // Any change of level restarts the debounce window.
      last_level_next     = level;
      debounce_timer_next = debounce_ms;
      debouncing_next     = 1'b1;
    end else if (debouncing) begin
      debounce_timer_next = dt_dec;
      if (dt_dec == '0) begin
        debouncing_next = 1'b0;
        held_ticks_next = '0;
        btn.press       = level;
        act             = 1'b1;
      end
    end else begin
      if (held_ticks != HELD_MAX) held_ticks_next = held_ticks + 1'b1;
      act = 1'b1;
    end

    if (act) begin
      if (!level) begin
        armed_next = 1'b1;
      end else if (armed) begin
        case (cur_state)
          ST_ON: begin
            if (want_state == ST_ON && held_ticks_next >= long_press_ms) begin
              btn.want   = ST_OFF;
              armed_next = 1'b0;
            end
          end
          ST_OFF: begin
            if (want_state == ST_OFF) begin
              btn.want   = ST_ON;
              armed_next = 1'b0;
            end
          end
          ST_FAULT, ST_FAULT_ON: begin
            btn.want   = ST_OFF;
            armed_next = 1'b0;
          end
          ST_FAULT_OFF: begin
            btn.want   = ST_CYCLE;
            armed_next = 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level     <= 1'b0;
      debouncing     <= 1'b0;
      debounce_timer <= '0;
      armed          <= 1'b0;
      held_ticks     <= '0;
    end else if (tick) begin
      last_level     <= last_level_next;
      debouncing     <= debouncing_next;
      debounce_timer <= debounce_timer_next;
      armed          <= armed_next;
      held_ticks     <= held_ticks_next;
    end
  end

endmodule

/* rtl/core/power_sequencer_with_button_unit.sv */
// ----------------------------------------------------------------------------
// power_sequencer_with_button_unit: supply sequencer with power button
// Nine-state supply sequencer driven by millisecond ticks, with debounce.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries request items: a one-millisecond tick (button level and
//   sensed supply state), a set of the desired state, or a start-up item.
//   status carries one item per request: current and desired state, the
//   supply-off pin level and a flag for a debounced press on this tick.
//   The configuration port writes timing registers and the cold-start mode;
//   write it only while no request is outstanding.
// Latency and throughput:
//   A request is processed in the cycle it is accepted; its status item is
//   valid in the next cycle. One request per cycle is taken, limited only by
//   the single status register: cmd.ready is high while that register is
//   empty or being emptied in the same cycle.
// Reset:
//   All states go to init, the supply-off pin is driven high, the timing
//   registers take their default values and the status register empties.
// Stall:
//   While status is stalled with a full register, cmd.ready stays low and
//   the held status item does not change.
// ----------------------------------------------------------------------------
module power_sequencer_with_button_unit
  import psb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  psb_in_if.sink                cmd,
  psb_out_if.source             status
);

  logic [TIME_W-1:0]  debounce_ms, long_press_ms, cycle_off_ms;
  logic [TIME_W-1:0]  on_timeout_ms, off_timeout_ms;
  logic               auto_on;

  logic [STATE_W-1:0] cur_state, cur_state_next;
  logic [STATE_W-1:0] want_state, want_state_next;
  logic [TIME_W-1:0]  seq_timer, seq_timer_next;
  logic               drive_level, drive_level_next;
  logic               press_next;

  logic               out_valid;
  logic               accept;
  logic               tick;
  psb_btn_t           btn;

  assign cmd.ready = !out_valid || status.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign tick      = accept && (cmd.req_type == REQ_TICK);

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms    <= DEBOUNCE_RST;
      long_press_ms  <= LONG_PRESS_RST;
      cycle_off_ms   <= CYCLE_OFF_RST;
      on_timeout_ms  <= ON_TIMEOUT_RST;
      off_timeout_ms <= OFF_TIMEOUT_RST;
      auto_on        <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE:    debounce_ms    <= cfg_wdata;
        CFG_LONG_PRESS:  long_press_ms  <= cfg_wdata;
        CFG_CYCLE_OFF:   cycle_off_ms   <= cfg_wdata;
        CFG_ON_TIMEOUT:  on_timeout_ms  <= cfg_wdata;
        CFG_OFF_TIMEOUT: off_timeout_ms <= cfg_wdata;
        CFG_AUTO_ON:     auto_on        <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  psb_button u_button (
    .clk           (clk),
    .rst           (rst),
    .tick          (tick),
    .level         (cmd.button_raw),
    .debounce_ms   (debounce_ms),
    .long_press_ms (long_press_ms),
    .cur_state     (cur_state),
    .want_state    (want_state),
    .btn           (btn)
  );

  always_comb begin
    logic [TIME_W-1:0] timer_dec;
    logic              elapsed;
    logic [STATE_W-1:0] want_b;
    cur_state_next   = cur_state;
    want_state_next  = want_state;
    seq_timer_next   = seq_timer;
    drive_level_next = drive_level;
    press_next       = 1'b0;
    timer_dec        = (seq_timer != '0) ? seq_timer - 1'b1 : '0;
    elapsed          = (timer_dec == '0);
    want_b           = btn.want;

    case (cmd.req_type)
      REQ_TICK: begin
        press_next      = btn.press;
        want_state_next = want_b;
        seq_timer_next  = timer_dec;
        if (cur_state != want_b) begin
          case (cur_state)
            ST_PWR_ON: begin
              if (cmd.sensed_state == ST_ON) begin
                cur_state_next = ST_ON;
              end else if (elapsed) begin
                cur_state_next  = ST_FAULT_ON;
                want_state_next = ST_FAULT_ON;
              end
            end
            ST_PWR_OFF: begin
              if (cmd.sensed_state == ST_OFF) begin
                cur_state_next = ST_OFF;
              end else if (elapsed) begin
                cur_state_next  = ST_FAULT_OFF;
                want_state_next = ST_FAULT_OFF;
              end
            end
            ST_CYCLE: begin
              if (elapsed) begin
                drive_level_next = 1'b0;
                cur_state_next   = ST_PWR_ON;
                want_state_next  = ST_ON;
                seq_timer_next   = on_timeout_ms;
              end
            end
            ST_ON: begin
              if (want_b == ST_OFF) begin
                drive_level_next = 1'b1;
                cur_state_next   = ST_PWR_OFF;
                seq_timer_next   = off_timeout_ms;
              end else if (want_b == ST_CYCLE) begin
                drive_level_next = 1'b1;
                cur_state_next   = ST_CYCLE;
                want_state_next  = ST_ON;
                seq_timer_next   = cycle_off_ms;
              end
            end
            ST_OFF: begin
              if (want_b == ST_ON || want_b == ST_CYCLE) begin
                drive_level_next = 1'b0;
                cur_state_next   = ST_PWR_ON;
                seq_timer_next   = off_timeout_ms;
              end
            end
            ST_FAULT, ST_FAULT_ON: begin
              if (want_b == ST_CYCLE || want_b == ST_ON) begin
                drive_level_next = 1'b1;
                cur_state_next   = ST_CYCLE;
                want_state_next  = ST_ON;
                seq_timer_next   = cycle_off_ms;
              end else if (want_b == ST_OFF) begin
                drive_level_next = 1'b1;
                cur_state_next   = ST_PWR_OFF;
                seq_timer_next   = off_timeout_ms;
              end
            end
            ST_FAULT_OFF: begin
              if (want_b == ST_CYCLE || want_b == ST_ON) begin
                drive_level_next = 1'b1;
                cur_state_next   = ST_CYCLE;
                want_state_next  = ST_ON;
                seq_timer_next   = cycle_off_ms;
              end
            end
            default: ;
          endcase
        end
      end
      REQ_SET: begin
        want_state_next = cmd.requested_state;
      end
      REQ_STARTUP: begin
        // A sensed init state leaves the desired state alone.
        cur_state_next = cmd.sensed_state;
        seq_timer_next = on_timeout_ms;
        if (cmd.sensed_state != ST_INIT) begin
          if (cmd.cold_start) want_state_next = auto_on ? ST_ON : ST_OFF;
          else                want_state_next = cmd.sensed_state;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_state   <= ST_INIT;
      want_state  <= ST_INIT;
      seq_timer   <= '0;
      drive_level <= 1'b1;
    end else if (accept) begin
      cur_state   <= cur_state_next;
      want_state  <= want_state_next;
      seq_timer   <= seq_timer_next;
      drive_level <= drive_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (status.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status.supply_state     <= cur_state_next;
      status.target_state     <= want_state_next;
      status.supply_off_drive <= drive_level_next;
      status.press_seen       <= press_next;
    end
  end

  assign status.valid = out_valid;

  // Every accepted request yields a status item in the following cycle.
  a_accept_gives_status: assert property (@(posedge clk) disable iff (rst)
    accept |=> status.valid)
    else $error("accepted request produced no status item");

  // Only ticks can report a debounced press.
  a_press_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.req_type != REQ_TICK |=> !status.press_seen)
    else $error("press reported for a non-tick request");

  // Sequencer state changes only on an accepted request.
  a_state_holds_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(cur_state) && $stable(want_state) && $stable(seq_timer))
    else $error("sequencer state changed without a request");

  // A set request writes the desired state exactly.
  a_set_writes_target: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.req_type == REQ_SET |=> want_state == $past(cmd.requested_state))
    else $error("set request did not write the desired state");

endmodule

/* tb/tb_power_sequencer_with_button_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_power_sequencer_with_button_unit: testbench for the power sequencer
// Drives request transfers with bursty pacing against a stalling status
// sink. Every accepted request is run through a local model of the button
// debouncer and the supply sequencer. Each status transfer is checked
// against the oldest predicted status.
// ----------------------------------------------------------------------------
module tb_power_sequencer_with_button_unit;
  import psb_pkg::*;

  // Request type that the block ignores.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]   req;
    logic               button;
    logic [STATE_W-1:0] sensed;
    logic [STATE_W-1:0] requested;
    logic               cold;
  } psb_req_t;

  typedef struct packed {
    logic [STATE_W-1:0] supply;
    logic [STATE_W-1:0] target;
    logic               off_drive;
    logic               press;
  } psb_status_t;

  typedef struct {
    logic [TIME_W-1:0] debounce;
    logic [TIME_W-1:0] long_press;
    logic [TIME_W-1:0] cycle_off;
    logic [TIME_W-1:0] on_timeout;
    logic [TIME_W-1:0] off_timeout;
    logic              auto_on;
  } psb_cfg_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  psb_in_if  cmd_bus ();
  psb_out_if status_bus ();

  power_sequencer_with_button_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd_bus),
    .status    (status_bus)
  );

  // Local copy of the sequencer state and its timing registers.
  psb_cfg_t           cfg;
  logic [STATE_W-1:0] sup_now, sup_goal;
  logic [TIME_W-1:0]  seq_count, settle_count, hold_count;
  logic               btn_last, btn_settling, btn_armed, off_pin;

  psb_status_t pending_status[$];
  psb_status_t got, due;

  int   mismatch_count = 0;
  int   n_checked = 0;
  int   n_requests = 0;
  int   n_presses = 0;
  logic [15:0] states_seen = '0;

  // Stimulus pacing state.
  logic steady = 1'b0;
  int   burst_left = 0;
  logic btn_level = 1'b0;
  int   btn_run = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Status prediction
  // ---------------------------------------------------------------------------
  function automatic psb_cfg_t settings_of(logic [TIME_W-1:0] db, logic [TIME_W-1:0] lp,
                                           logic [TIME_W-1:0] co, logic [TIME_W-1:0] ont,
                                           logic [TIME_W-1:0] offt, logic ao);
    psb_cfg_t s;
    s.debounce    = db;
    s.long_press  = lp;
    s.cycle_off   = co;
    s.on_timeout  = ont;
    s.off_timeout = offt;
    s.auto_on     = ao;
    return s;
  endfunction

  // Returns 1 when a debounce ends with the button pressed.
  function automatic logic debounce_button(logic level);
    logic pressed;
    pressed = 1'b0;
    if (level != btn_last) begin
      btn_last     = level;
      settle_count = cfg.debounce;
      btn_settling = 1'b1;
      return 1'b0;
    end
    if (btn_settling) begin
      if (settle_count != 0) settle_count--;
      if (settle_count != 0) return 1'b0;
      btn_settling = 1'b0;
      hold_count   = '0;
      pressed      = level;
    end else if (hold_count != HELD_MAX) begin
      hold_count++;
    end
    if (!level) begin
      btn_armed = 1'b1;
      return pressed;
    end
    if (!btn_armed) return pressed;
    case (sup_now)
      ST_ON: begin
        if (sup_goal == ST_ON && hold_count >= cfg.long_press) begin
          sup_goal  = ST_OFF;
          btn_armed = 1'b0;
        end
      end
      ST_OFF: begin
        if (sup_goal == ST_OFF) begin
          sup_goal  = ST_ON;
          btn_armed = 1'b0;
        end
      end
      ST_FAULT, ST_FAULT_ON: begin
        sup_goal  = ST_OFF;
        btn_armed = 1'b0;
      end
      ST_FAULT_OFF: begin
        sup_goal  = ST_CYCLE;
        btn_armed = 1'b0;
      end
      default: ;
    endcase
    return pressed;
  endfunction

  function automatic void start_power_off();
    off_pin   = 1'b1;
    sup_now   = ST_PWR_OFF;
    seq_count = cfg.off_timeout;
  endfunction

  function automatic void start_power_cycle();
    off_pin   = 1'b1;
    sup_now   = ST_CYCLE;
    sup_goal  = ST_ON;
    seq_count = cfg.cycle_off;
  endfunction

  function automatic void sequence_step(logic [STATE_W-1:0] sensed);
    logic elapsed;
    if (seq_count != 0) seq_count--;
    elapsed = (seq_count == 0);
    if (sup_now == sup_goal) return;
    case (sup_now)
      ST_PWR_ON: begin
        if (sensed == ST_ON) begin
          sup_now = ST_ON;
        end else if (elapsed) begin
          sup_now  = ST_FAULT_ON;
          sup_goal = ST_FAULT_ON;
        end
      end
      ST_PWR_OFF: begin
        if (sensed == ST_OFF) begin
          sup_now = ST_OFF;
        end else if (elapsed) begin
          sup_now  = ST_FAULT_OFF;
          sup_goal = ST_FAULT_OFF;
        end
      end
      ST_CYCLE: begin
        if (elapsed) begin
          off_pin   = 1'b0;
          sup_now   = ST_PWR_ON;
          sup_goal  = ST_ON;
          seq_count = cfg.on_timeout;
        end
      end
      ST_ON: begin
        if (sup_goal == ST_OFF) start_power_off();
        else if (sup_goal == ST_CYCLE) start_power_cycle();
      end
      ST_OFF: begin
        if (sup_goal == ST_ON || sup_goal == ST_CYCLE) begin
          off_pin   = 1'b0;
          sup_now   = ST_PWR_ON;
          seq_count = cfg.off_timeout;
        end
      end
      ST_FAULT, ST_FAULT_ON: begin
        if (sup_goal == ST_CYCLE || sup_goal == ST_ON) start_power_cycle();
        else if (sup_goal == ST_OFF) start_power_off();
      end
      ST_FAULT_OFF: begin
        if (sup_goal == ST_CYCLE || sup_goal == ST_ON) start_power_cycle();
      end
      default: ;
    endcase
  endfunction

  function automatic psb_status_t advance_sequencer(psb_req_t r);
    logic pressed;
    pressed = 1'b0;
    case (r.req)
      REQ_TICK: begin
        pressed = debounce_button(r.button);
        sequence_step(r.sensed);
      end
      REQ_SET: sup_goal = r.requested;
      REQ_STARTUP: begin
        sup_now   = r.sensed;
        seq_count = cfg.on_timeout;
        if (sup_now != ST_INIT) begin
          if (r.cold) sup_goal = cfg.auto_on ? ST_ON : ST_OFF;
          else sup_goal = sup_now;
        end
      end
      default: ;
    endcase
    n_requests++;
    if (pressed) n_presses++;
    states_seen[sup_now] = 1'b1;
    return '{sup_now, sup_goal, off_pin, pressed};
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  function automatic psb_req_t make_req(logic [REQ_W-1:0] req, logic button,
                                        logic [STATE_W-1:0] sensed,
                                        logic [STATE_W-1:0] requested, logic cold);
    return '{req, button, sensed, requested, cold};
  endfunction

  task automatic send_request(input psb_req_t r);
    cmd_bus.valid           <= 1'b1;
    cmd_bus.req_type        <= r.req;
    cmd_bus.button_raw      <= r.button;
    cmd_bus.sensed_state    <= r.sensed;
    cmd_bus.requested_state <= r.requested;
    cmd_bus.cold_start      <= r.cold;
    do @(posedge clk); while (!cmd_bus.ready);
    pending_status.push_back(advance_sequencer(r));
  endtask

  // Bursts of random length separated by random gaps, unless steady is set.
  task automatic send_paced(input psb_req_t r);
    if (!steady && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        cmd_bus.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    if (burst_left != 0) burst_left--;
    send_request(r);
  endtask

  task automatic send_item(logic [REQ_W-1:0] req, logic button, logic [STATE_W-1:0] sensed,
                           logic [STATE_W-1:0] requested, logic cold);
    send_paced(make_req(req, button, sensed, requested, cold));
  endtask

  task automatic wait_status_drained();
    cmd_bus.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Only called with the block idle, so the local copy can change at once.
  task automatic apply_settings(input psb_cfg_t s);
    write_register(CFG_DEBOUNCE, s.debounce);
    write_register(CFG_LONG_PRESS, s.long_press);
    write_register(CFG_CYCLE_OFF, s.cycle_off);
    write_register(CFG_ON_TIMEOUT, s.on_timeout);
    write_register(CFG_OFF_TIMEOUT, s.off_timeout);
    write_register(CFG_AUTO_ON, {{(CFG_DATA_W-1){1'b0}}, s.auto_on});
    cfg_we <= 1'b0;
    cfg = s;
  endtask

  // ---------------------------------------------------------------------------
  // Random request generation
  // ---------------------------------------------------------------------------
  function automatic int hold_span();
    int lim;
    lim = int'(cfg.debounce) + int'(cfg.long_press) + 4;
    if (lim > 400) lim = 400;
    if ($urandom_range(0, 4) == 0) return $urandom_range(1, 3);
    return $urandom_range(1, lim);
  endfunction

  // Four times in ten reports what the sequencer waits for, so that power-up and
  // power-down complete; otherwise a random state, which lets timeouts fire.
  function automatic logic [STATE_W-1:0] sense_supply();
    if ($urandom_range(0, 9) < 4) begin
      case (sup_now)
        ST_PWR_ON:           return ST_ON;
        ST_PWR_OFF, ST_CYCLE: return ST_OFF;
        default:             return sup_now;
      endcase
    end
    return STATE_W'($urandom_range(0, 8));
  endfunction

  function automatic logic [STATE_W-1:0] pick_state();
    case ($urandom_range(0, 4))
      0:       return ST_ON;
      1:       return ST_OFF;
      2:       return ST_CYCLE;
      default: return STATE_W'($urandom_range(0, 8));
    endcase
  endfunction

  function automatic psb_req_t pick_request();
    psb_req_t r;
    int       roll;
    r    = make_req(REQ_TICK, 1'($urandom_range(0, 1)), STATE_W'($urandom_range(0, 8)),
                    STATE_W'($urandom_range(0, 8)), 1'($urandom_range(0, 1)));
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      r.req       = REQ_SET;
      r.requested = pick_state();
    end else if (roll < 9) begin
      r.req    = REQ_STARTUP;
      r.sensed = pick_state();
    end else begin
      if (btn_run == 0) begin
        btn_level = ~btn_level;
        btn_run   = hold_span();
      end
      btn_run--;
      // An occasional one-tick bounce restarts the debounce.
      r.button = ($urandom_range(0, 49) == 0) ? ~btn_level : btn_level;
      r.sensed = sense_supply();
    end
    return r;
  endfunction

  function automatic psb_cfg_t pick_settings(int kind);
    case (kind)
      1: return settings_of(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 1'b0);
      3: return settings_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      4: return settings_of(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
      5: return settings_of(DEBOUNCE_RST, LONG_PRESS_RST, CYCLE_OFF_RST, ON_TIMEOUT_RST,
                            OFF_TIMEOUT_RST, 1'b0);
      default: return settings_of(TIME_W'($urandom_range(1, 4)),
                                  TIME_W'($urandom_range(1, 10)),
                                  TIME_W'($urandom_range(1, 8)),
                                  TIME_W'($urandom_range(1, 12)),
                                  TIME_W'($urandom_range(1, 12)),
                                  1'($urandom_range(0, 1)));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_defaults();
    send_item(REQ_TICK, 1'b0, ST_INIT, ST_INIT, 1'b0);
    // Start-up that senses init keeps the desired state.
    send_item(REQ_STARTUP, 1'b0, ST_INIT, ST_INIT, 1'b1);
    send_item(REQ_TICK, 1'b1, ST_OFF, ST_FAULT_OFF, 1'b0);
  endtask

  task automatic test_button_sequence();
    int k;
    wait_status_drained();
    apply_settings(settings_of(16'd1, 16'd2, 16'd2, 16'd3, 16'd3, 1'b0));
    send_item(REQ_STARTUP, 1'b0, ST_OFF, ST_INIT, 1'b1);
    // Release, then a short press from off powers on.
    for (k = 0; k < 2; k++) send_item(REQ_TICK, 1'b0, ST_OFF, ST_INIT, 1'b0);
    for (k = 0; k < 2; k++) send_item(REQ_TICK, 1'b1, ST_OFF, ST_INIT, 1'b0);
    send_item(REQ_TICK, 1'b1, ST_ON, ST_INIT, 1'b0);
    // Release, then hold long enough to power off.
    for (k = 0; k < 2; k++) send_item(REQ_TICK, 1'b0, ST_ON, ST_INIT, 1'b0);
    for (k = 0; k < 4; k++) send_item(REQ_TICK, 1'b1, ST_ON, ST_INIT, 1'b0);
    send_item(REQ_TICK, 1'b1, ST_OFF, ST_INIT, 1'b0);
  endtask

  task automatic test_fault_recovery();
    int k;
    wait_status_drained();
    apply_settings(settings_of(16'd1, 16'd2, 16'd2, 16'd3, 16'd3, 1'b1));
    send_item(REQ_STARTUP, 1'b1, ST_ON, ST_INIT, 1'b1);
    send_item(REQ_SET, 1'b1, ST_ON, ST_OFF, 1'b0);
    // The rails never report off, so power-down times out into a fault.
    for (k = 0; k < 4; k++) send_item(REQ_TICK, 1'b1, ST_ON, ST_INIT, 1'b0);
    send_item(REQ_STARTUP, 1'b1, ST_FAULT_ON, ST_INIT, 1'b0);
    send_item(REQ_SET, 1'b1, ST_FAULT_ON, ST_ON, 1'b0);
    send_item(REQ_TICK, 1'b1, ST_FAULT_ON, ST_INIT, 1'b0);
  endtask

  task automatic test_undefined_codes();
    // The unused request type and state codes outside the encoding.
    send_item(REQ_UNUSED, 1'b1, 4'hF, 4'hF, 1'b1);
    send_item(REQ_STARTUP, 1'b0, 4'hF, ST_INIT, 1'b0);
    send_item(REQ_TICK, 1'b1, 4'hF, 4'hF, 1'b1);
    send_item(REQ_SET, 1'b0, ST_INIT, 4'd9, 1'b0);
  endtask

  // Holds the button well past the long-press time while the sequencer sits
  // in an undefined state, then checks that the accumulated hold powers off
  // as soon as the supply is on.
  task automatic test_long_hold();
    int k;
    wait_status_drained();
    apply_settings(settings_of(16'd1, 16'd100, 16'd1, 16'd1, 16'd1, 1'b0));
    steady = 1'b1;
    send_item(REQ_STARTUP, 1'b0, 4'd9, ST_INIT, 1'b0);
    for (k = 0; k < 3; k++) send_item(REQ_TICK, 1'b0, 4'd9, ST_INIT, 1'b0);
    for (k = 0; k < 110; k++) send_item(REQ_TICK, 1'b1, 4'd9, ST_INIT, 1'b0);
    send_item(REQ_STARTUP, 1'b1, ST_ON, ST_INIT, 1'b0);
    send_item(REQ_TICK, 1'b1, ST_ON, ST_INIT, 1'b0);
    send_item(REQ_TICK, 1'b1, ST_OFF, ST_INIT, 1'b0);
    steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    int kind, k;
    for (kind = 0; kind < 8; kind++) begin
      wait_status_drained();
      apply_settings(pick_settings(kind));
      steady = (kind == 2 || kind == 6);
      for (k = 0; k < 130; k++) begin
        if ($urandom_range(0, 99) == 0) wait_status_drained();
        send_paced(pick_request());
      end
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Status sink: the stall mix changes over spans of random length.
  // ---------------------------------------------------------------------------
  initial begin
    int span, stall_pct;
    span      = 0;
    stall_pct = 0;
    status_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        span = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      span--;
      status_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && status_bus.valid && status_bus.ready) begin
      got = '{status_bus.supply_state, status_bus.target_state,
              status_bus.supply_off_drive, status_bus.press_seen};
      n_checked++;
      if (pending_status.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: status transfer with none predicted:", $realtime,
                   " supply %0d target %0d off %0b press %0b",
                   got.supply, got.target, got.off_drive, got.press);
      end else begin
        due = pending_status.pop_front();
        if (got.supply !== due.supply || got.target !== due.target ||
            got.off_drive !== due.off_drive || got.press !== due.press) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: status mismatch:", $realtime,
                     " expected supply %0d target %0d off %0b press %0b,",
                     due.supply, due.target, due.off_drive, due.press,
                     " got supply %0d target %0d off %0b press %0b",
                     got.supply, got.target, got.off_drive, got.press);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d status transfers still outstanding.", pending_status.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst                     <= 1'b1;
    cfg_we                  <= 1'b0;
    cfg_index               <= CFG_DEBOUNCE;
    cfg_wdata               <= '0;
    cmd_bus.valid           <= 1'b0;
    cmd_bus.req_type        <= REQ_TICK;
    cmd_bus.button_raw      <= 1'b0;
    cmd_bus.sensed_state    <= ST_INIT;
    cmd_bus.requested_state <= ST_INIT;
    cmd_bus.cold_start      <= 1'b0;
    cfg = settings_of(DEBOUNCE_RST, LONG_PRESS_RST, CYCLE_OFF_RST, ON_TIMEOUT_RST,
                      OFF_TIMEOUT_RST, 1'b0);
    sup_now      = ST_INIT;
    sup_goal     = ST_INIT;
    seq_count    = '0;
    settle_count = '0;
    hold_count   = '0;
    btn_last     = 1'b0;
    btn_settling = 1'b0;
    btn_armed    = 1'b0;
    off_pin      = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_button_sequence();
    test_fault_recovery();
    test_undefined_codes();
    test_long_hold();
    test_random_traffic();
    wait_status_drained();

    if (pending_status.size() != 0) mismatch_count++;
    $display("Sent %0d requests (directed, long hold, random phases);", n_requests,
             " checked %0d status transfers.", n_checked);
    $display("Predicted %0d debounced presses; supply states visited %b; mismatches %0d.",
             n_presses, states_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/psb_pkg.sv
rtl/core/psb_if.sv
rtl/core/psb_button.sv
rtl/core/power_sequencer_with_button_unit.sv
tb/tb_power_sequencer_with_button_unit.sv
